// ===== hw/rtl/rgb_pixel_requantizer_assert.svh =====
// ----------------------------------------------------------------------------
// RGB pixel requantizer assertion macros
// Concurrent assertion wrappers sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_PIXEL_REQUANTIZER_ASSERT_SVH
`define RGB_PIXEL_REQUANTIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_pixel_requantizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_pixel_requantizer assertion failed");

`endif

// ===== hw/rtl/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB pixel requantizer package
// Register map, datapath widths and the per-channel requantize function.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 32;
    localparam int OFS_W   = 48;
    localparam int SHIFT_W = 6;
    localparam int QUANT_W = 8;
    localparam int PROD_W  = PIX_W + 1 + GAIN_W;
    localparam int RS_W    = 51;

    // Any shift at or above this value rounds every reachable value to zero.
    localparam logic [SHIFT_W-1:0] SH_ZERO = 6'd50;

    localparam logic signed [RS_W-1:0] Q_MAX = 51'sd127;
    localparam logic signed [RS_W-1:0] Q_MIN = -51'sd128;

    typedef enum logic [2:0] {
        REG_RED_GAIN     = 3'd0,
        REG_GREEN_GAIN   = 3'd1,
        REG_BLUE_GAIN    = 3'd2,
        REG_RED_OFFSET   = 3'd3,
        REG_GREEN_OFFSET = 3'd4,
        REG_BLUE_OFFSET  = 3'd5,
        REG_SHIFT        = 3'd6,
        REG_MODE         = 3'd7
    } reg_idx_t;

    // Add half a step, take one off for negative values, then shift with floor.
    function automatic logic signed [RS_W-1:0] rpr_round(
        input logic signed [RS_W-1:0] v,
        input logic [SHIFT_W-1:0]     sh
    );
        logic signed [RS_W-1:0] half;
        logic signed [RS_W-1:0] t;
        logic signed [RS_W-1:0] r;
        half = '0;
        t    = v;
        if (sh == '0) begin
            r = v;
        end else if (sh >= SH_ZERO) begin
            r = '0;
        end else begin
            half = signed'(RS_W'(1) << (sh - SHIFT_W'(1)));
            t    = v + half - signed'({{(RS_W-1){1'b0}}, v[RS_W-1]});
            r    = t >>> sh;
        end
        return r;
    endfunction

    function automatic logic signed [QUANT_W-1:0] rpr_sat(input logic signed [RS_W-1:0] v);
        logic signed [QUANT_W-1:0] r;
        if (v > Q_MAX) begin
            r = QUANT_W'(Q_MAX);
        end else if (v < Q_MIN) begin
            r = QUANT_W'(Q_MIN);
        end else begin
            r = signed'(v[QUANT_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [QUANT_W-1:0] rpr_channel(
        input logic [PIX_W-1:0]          pix,
        input logic signed [GAIN_W-1:0]  gain,
        input logic signed [OFS_W-1:0]   offset,
        input logic [SHIFT_W-1:0]        sh,
        input logic                      after
    );
        logic signed [PIX_W:0]    pix_s;
        logic signed [PROD_W-1:0] prod;
        logic signed [RS_W-1:0]   val;
        pix_s = signed'({1'b0, pix});
        prod  = PROD_W'(pix_s) * PROD_W'(gain);
        if (after) begin
            val = rpr_round(RS_W'(prod), sh) + RS_W'(offset);
        end else begin
            val = rpr_round(RS_W'(prod) + RS_W'(offset), sh);
        end
        return rpr_sat(val);
    endfunction

endpackage

// ===== hw/rtl/rgb_pixel_requantizer.sv =====
// ----------------------------------------------------------------------------
// RGB pixel requantizer
// Scales, offsets, rounds and saturates RGB bytes into signed int8 values.
// ----------------------------------------------------------------------------
// Each word carries one pixel and yields one word of three int8 values at a
// sustained rate of one pixel per clock while the result is not stalled. A
// word is held in an input register, then the per-channel multiply, offset add
// (post-shift in mode 1), rounding shift and saturation run in one pass into
// the result register. The input side stalls only when both registers are full
// and the result is being stalled. Configuration is written over the APB port
// at byte address 8*i, with 64-bit data, and should change only while idle.
`include "rgb_pixel_requantizer_assert.svh"

module rgb_pixel_requantizer
    import rpr_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ADDR_W-1:0]                 paddr,
    input  logic [DATA_W-1:0]                 pwdata,
    output logic [DATA_W-1:0]                 prdata,
    output logic                              pready,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [PIX_W-1:0]                  red_pixel,
    input  logic [PIX_W-1:0]                  green_pixel,
    input  logic [PIX_W-1:0]                  blue_pixel,
    output logic                              quant_valid,
    input  logic                              quant_stall,
    output logic signed [QUANT_W-1:0]         red_quant,
    output logic signed [QUANT_W-1:0]         green_quant,
    output logic signed [QUANT_W-1:0]         blue_quant
);

    logic signed [GAIN_W-1:0]  red_gain_reg;
    logic signed [GAIN_W-1:0]  green_gain_reg;
    logic signed [GAIN_W-1:0]  blue_gain_reg;
    logic signed [OFS_W-1:0]   red_offset_reg;
    logic signed [OFS_W-1:0]   green_offset_reg;
    logic signed [OFS_W-1:0]   blue_offset_reg;
    logic [SHIFT_W-1:0]        shift_reg;
    logic                      mode_reg;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [PIX_W-1:0]          red_pix_reg;
    logic [PIX_W-1:0]          green_pix_reg;
    logic [PIX_W-1:0]          blue_pix_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [QUANT_W-1:0] red_quant_reg;
    logic signed [QUANT_W-1:0] green_quant_reg;
    logic signed [QUANT_W-1:0] blue_quant_reg;

    logic                      cfg_write;
    reg_idx_t                  cfg_idx;
    logic                      out_ready;
    logic                      advance;
    logic                      take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_gain_reg     <= '0;
            green_gain_reg   <= '0;
            blue_gain_reg    <= '0;
            red_offset_reg   <= '0;
            green_offset_reg <= '0;
            blue_offset_reg  <= '0;
            shift_reg        <= '0;
            mode_reg         <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_RED_GAIN:     red_gain_reg     <= signed'(pwdata[GAIN_W-1:0]);
                REG_GREEN_GAIN:   green_gain_reg   <= signed'(pwdata[GAIN_W-1:0]);
                REG_BLUE_GAIN:    blue_gain_reg    <= signed'(pwdata[GAIN_W-1:0]);
                REG_RED_OFFSET:   red_offset_reg   <= signed'(pwdata[OFS_W-1:0]);
                REG_GREEN_OFFSET: green_offset_reg <= signed'(pwdata[OFS_W-1:0]);
                REG_BLUE_OFFSET:  blue_offset_reg  <= signed'(pwdata[OFS_W-1:0]);
                REG_SHIFT:        shift_reg        <= pwdata[SHIFT_W-1:0];
                REG_MODE:         mode_reg         <= pwdata[0];
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_RED_GAIN:     prdata = DATA_W'(unsigned'(red_gain_reg));
            REG_GREEN_GAIN:   prdata = DATA_W'(unsigned'(green_gain_reg));
            REG_BLUE_GAIN:    prdata = DATA_W'(unsigned'(blue_gain_reg));
            REG_RED_OFFSET:   prdata = DATA_W'(unsigned'(red_offset_reg));
            REG_GREEN_OFFSET: prdata = DATA_W'(unsigned'(green_offset_reg));
            REG_BLUE_OFFSET:  prdata = DATA_W'(unsigned'(blue_offset_reg));
            REG_SHIFT:        prdata = DATA_W'(shift_reg);
            REG_MODE:         prdata = DATA_W'(mode_reg);
            default:          prdata = '0;
        endcase
    end

    assign out_ready   = !out_valid_reg || !quant_stall;
    assign advance     = in_valid_reg && out_ready;
    assign pixel_stall = in_valid_reg && !out_ready;
    assign take        = pixel_valid && !pixel_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!quant_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            red_pix_reg   <= red_pixel;
            green_pix_reg <= green_pixel;
            blue_pix_reg  <= blue_pixel;
        end
        if (advance)
        begin
            red_quant_reg   <= rpr_channel(red_pix_reg, red_gain_reg, red_offset_reg,
                                           shift_reg, mode_reg);
            green_quant_reg <= rpr_channel(green_pix_reg, green_gain_reg, green_offset_reg,
                                           shift_reg, mode_reg);
            blue_quant_reg  <= rpr_channel(blue_pix_reg, blue_gain_reg, blue_offset_reg,
                                           shift_reg, mode_reg);
        end
    end

    assign quant_valid = out_valid_reg;
    assign red_quant   = red_quant_reg;
    assign green_quant = green_quant_reg;
    assign blue_quant  = blue_quant_reg;

    `RPR_ASSERT_NOW(a_stall_needs_full, pixel_stall, in_valid_reg && out_valid_reg)
    `RPR_ASSERT_NEXT(a_take_fills_input, take, in_valid_reg)
    `RPR_ASSERT_NEXT(a_advance_gives_result, advance, quant_valid)
    `RPR_ASSERT_NEXT(a_zero_config_zero_result,
        advance && red_gain_reg == '0 && red_offset_reg == '0,
        red_quant == '0)

endmodule

// ===== tb/sv/rgb_pixel_requantizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB pixel requantizer testbench
// Streams RGB words through the requantizer under several register settings,
// with random idle cycles on both sides, and checks every quantized word
// against a local fixed-point predictor of the gain, offset, rounding shift
// and saturation.
// ----------------------------------------------------------------------------
module rgb_pixel_requantizer_test
    import rpr_pkg::*;
();

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_PERCENT = 19;
    localparam int DRAIN_CYCLES = 6;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 40;
    localparam longint SAT_HI   = 127;
    localparam longint SAT_LO   = -128;

    typedef struct {
        logic signed [QUANT_W-1:0] red;
        logic signed [QUANT_W-1:0] green;
        logic signed [QUANT_W-1:0] blue;
    } quant_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      pixel_valid = 1'b0;
    logic                      pixel_stall;
    logic [PIX_W-1:0]          red_pixel = '0;
    logic [PIX_W-1:0]          green_pixel = '0;
    logic [PIX_W-1:0]          blue_pixel = '0;
    logic                      quant_valid;
    logic                      quant_stall = 1'b0;
    logic signed [QUANT_W-1:0] red_quant;
    logic signed [QUANT_W-1:0] green_quant;
    logic signed [QUANT_W-1:0] blue_quant;

    logic signed [31:0] gain_mirror [3];
    logic signed [47:0] offset_mirror [3];
    logic [5:0]         shift_mirror;
    logic               after_mirror;

    quant_word_t pending_quant [$];
    bit          steady = 1'b0;
    int          error_count = 0;
    int          cycle_count = 0;

    rgb_pixel_requantizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red_pixel   (red_pixel),
        .green_pixel (green_pixel),
        .blue_pixel  (blue_pixel),
        .quant_valid (quant_valid),
        .quant_stall (quant_stall),
        .red_quant   (red_quant),
        .green_quant (green_quant),
        .blue_quant  (blue_quant)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("rgb_pixel_requantizer_test: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        quant_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    function automatic logic signed [QUANT_W-1:0] predict_quant(
        input logic [PIX_W-1:0] pix,
        input int               ch
    );
        longint prod;
        longint v;
        longint ofs;
        int unsigned sh;
        prod = longint'({56'd0, pix}) * longint'(gain_mirror[ch]);
        ofs  = longint'(offset_mirror[ch]);
        sh   = shift_mirror;
        v    = after_mirror ? prod : prod + ofs;
        if (sh != 0)
        begin
            v = (v + (longint'(1) << (sh - 1)) - ((v < 0) ? 64'sd1 : 64'sd0)) >>> sh;
        end
        if (after_mirror)
        begin
            v = v + ofs;
        end
        if (v > SAT_HI)
        begin
            v = SAT_HI;
        end
        if (v < SAT_LO)
        begin
            v = SAT_LO;
        end
        return v[QUANT_W-1:0];
    endfunction

    task automatic report_mismatch(
        input string                     field,
        input logic signed [QUANT_W-1:0] got,
        input logic signed [QUANT_W-1:0] want
    );
        if (error_count < MAX_REPORTS)
        begin
            $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                     cycle_count, field, got, want);
        end
        error_count++;
    endtask

    always @(posedge clk)
    begin
        quant_word_t want;
        if (rst_n && quant_valid && !quant_stall)
        begin
            if (pending_quant.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                begin
                    $display("unexpected word at cycle %0d", cycle_count);
                end
                error_count++;
            end
            else
            begin
                want = pending_quant.pop_front();
                if (red_quant !== want.red)
                begin
                    report_mismatch("red_quant", red_quant, want.red);
                end
                if (green_quant !== want.green)
                begin
                    report_mismatch("green_quant", green_quant, want.green);
                end
                if (blue_quant !== want.blue)
                begin
                    report_mismatch("blue_quant", blue_quant, want.blue);
                end
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RED_GAIN:     gain_mirror[0] = data[31:0];
            REG_GREEN_GAIN:   gain_mirror[1] = data[31:0];
            REG_BLUE_GAIN:    gain_mirror[2] = data[31:0];
            REG_RED_OFFSET:   offset_mirror[0] = data[47:0];
            REG_GREEN_OFFSET: offset_mirror[1] = data[47:0];
            REG_BLUE_OFFSET:  offset_mirror[2] = data[47:0];
            REG_SHIFT:        shift_mirror = data[5:0];
            REG_MODE:         after_mirror = data[0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // Upper bits of every write carry random junk, which the block must ignore.
    task automatic apply_settings(
        input longint      rg,
        input longint      gg,
        input longint      bg,
        input longint      ro,
        input longint      go,
        input longint      bo,
        input int unsigned sh,
        input bit          after
    );
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_RED_GAIN, {junk[63:32], rg[31:0]});
        write_reg(REG_GREEN_GAIN, {junk[31:0], gg[31:0]});
        write_reg(REG_BLUE_GAIN, {junk[47:16], bg[31:0]});
        write_reg(REG_RED_OFFSET, {junk[63:48], ro[47:0]});
        write_reg(REG_GREEN_OFFSET, {junk[15:0], go[47:0]});
        write_reg(REG_BLUE_OFFSET, {junk[39:24], bo[47:0]});
        write_reg(REG_SHIFT, {junk[57:0], sh[5:0]});
        write_reg(REG_MODE, {junk[63:1], after});
    endtask

    task automatic send_pixel(
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] b
    );
        quant_word_t w;
        while (!steady && ($urandom_range(99) < IDLE_PERCENT))
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        red_pixel   <= r;
        green_pixel <= g;
        blue_pixel  <= b;
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
        w.red   = predict_quant(r, 0);
        w.green = predict_quant(g, 1);
        w.blue  = predict_quant(b, 2);
        pending_quant.push_back(w);
    endtask

    task automatic wait_drained;
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_quant.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel;
        int unsigned c;
        c = $urandom_range(15);
        if (c == 0)
        begin
            return 8'd0;
        end
        if (c == 1)
        begin
            return 8'd255;
        end
        return PIX_W'($urandom_range(255));
    endfunction

    function automatic longint pick_gain(input int unsigned sh);
        longint mag;
        mag = longint'($urandom_range(0, 32'h8000_0000 >> (31 - sh)));
        return $urandom_range(1) ? -mag : ((mag > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : mag);
    endfunction

    function automatic longint pick_offset(input int unsigned sh, input bit after);
        longint unsigned u;
        u = {$urandom, $urandom};
        if ($urandom_range(5) == 0)
        begin
            return longint'({{16{u[47]}}, u[47:0]});
        end
        if (after)
        begin
            return longint'($urandom_range(511)) - 256;
        end
        return longint'(u % (64'd1 << (sh + 8))) - (longint'(1) << (sh + 7));
    endfunction

    task automatic stream_random(input int count);
        repeat (count)
        begin
            send_pixel(pick_pixel(), pick_pixel(), pick_pixel());
        end
        wait_drained();
    endtask

    task automatic test_reset_state;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        wait_drained();
    endtask

    task automatic test_directed_extremes;
        // No shift: full-scale gains saturate both ways, offset alone shows through.
        apply_settings(64'sh7FFF_FFFF, -64'sh8000_0000, 1, 0, 0, -1, 0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd1, 8'd128);
        wait_drained();
        // Shift by one: halves round away from zero on both signs.
        apply_settings(1, -1, 1, 0, 0, 0, 1, 1'b0);
        send_pixel(8'd3, 8'd3, 8'd1);
        send_pixel(8'd255, 8'd255, 8'd254);
        wait_drained();
        // Largest shift with extreme offsets, in both modes.
        apply_settings(64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF,
                       64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000, 0, 63, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd128, 8'd7);
        wait_drained();
        write_reg(REG_MODE, 64'd1);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_drained();
        // Zero point after the shift, the usual image normalization.
        apply_settings(256, 256, -256, -128, -128, 127, 8, 1'b1);
        send_pixel(8'd0, 8'd128, 8'd255);
        send_pixel(8'd255, 8'd127, 8'd0);
        wait_drained();
        // Shift at and around the point where everything rounds to zero.
        apply_settings(64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF,
                       64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000, 64'sh4000_0000_0000,
                       49, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255);
        wait_drained();
        write_reg(REG_SHIFT, 64'd50);
        send_pixel(8'd255, 8'd255, 8'd255);
        wait_drained();
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        int unsigned sh;
        bit          after;
        repeat (phases)
        begin
            sh    = $urandom_range(31);
            after = $urandom_range(1);
            apply_settings(pick_gain(sh), pick_gain(sh), pick_gain(sh),
                           pick_offset(sh, after), pick_offset(sh, after),
                           pick_offset(sh, after), sh, after);
            stream_random(per_phase);
        end
    endtask

    task automatic test_full_range_settings(input int phases, input int per_phase);
        repeat (phases)
        begin
            apply_settings(longint'(int'($urandom)), longint'(int'($urandom)),
                           longint'(int'($urandom)),
                           pick_offset(40, 1'b0), pick_offset(40, 1'b0),
                           pick_offset(40, 1'b0), $urandom_range(63), $urandom_range(1));
            stream_random(per_phase);
        end
    endtask

    task automatic test_steady_stream(input int count);
        int unsigned sh;
        sh     = $urandom_range(6, 20);
        steady = 1'b1;
        apply_settings(pick_gain(sh), pick_gain(sh), pick_gain(sh),
                       pick_offset(sh, 1'b0), pick_offset(sh, 1'b0),
                       pick_offset(sh, 1'b0), sh, 1'b0);
        stream_random(count);
        steady = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            gain_mirror[i]   = '0;
            offset_mirror[i] = '0;
        end
        shift_mirror = '0;
        after_mirror = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_extremes();
        test_random_settings(10, 80);
        test_steady_stream(150);
        test_full_range_settings(2, 50);
        if (error_count == 0)
        begin
            $display("rgb_pixel_requantizer_test: clean");
        end
        else
        begin
            $display("rgb_pixel_requantizer_test: errors");
        end
        $finish;
    end

endmodule
